>>> rtl/assert_macros.svh
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define SCTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define SCTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked also around reset
`define SCTR_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/sctr_pkg.sv
package sctr_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int WORD_W  = 16;
    localparam int VBASE_W = 9;
    localparam int VEC_W   = 10;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd2;

    // register word offsets
    localparam logic [1:0] PORT_RCSR = 2'd0;
    localparam logic [1:0] PORT_RBUF = 2'd1;
    localparam logic [1:0] PORT_XCSR = 2'd2;
    localparam logic [1:0] PORT_XBUF = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_BASE = 1'd1;

    localparam logic [WORD_W-1:0]  BASE_ADDR_RST   = 16'hFF70;
    localparam logic [VBASE_W-1:0] VECTOR_BASE_RST = 9'd48;
    localparam logic [VEC_W-1:0]   XMIT_VEC_OFS    = 10'd4;

    localparam int READY_POS  = 7;
    localparam int ENABLE_POS = 6;

    typedef struct packed {
        logic [WORD_W-1:0] rdata;
        logic              ok;
        logic              trap;
        logic              irq;
        logic [VEC_W-1:0]  vec;
        logic              txv;
        logic [WORD_W-1:0] txc;
    } t_result;

endpackage

>>> rtl/sctr_ram.sv
module sctr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/serial_console_terminal_regs_top.sv
// console terminal register block: receiver status/data, transmitter status/data
// input channel (i_valid/o_ready) carries one word: a bus read, a bus write or
//   a keyboard character push, selected by i_cmd
// output channel (o_valid/i_ready) returns exactly one result word per input word
// configuration: i_cfg_we writes base address (index 0) or vector base (index 1);
//   write it only while the block is idle, the block itself does not enforce this
// throughput: one word per cycle while the receiver does not stall, set by the
//   single read and single write port of the keyboard ring memory; an accepted
//   word passes the registered ring read in stage P, then the output register
// a pop is accepted only once the head pointer has moved past its entry, which the
//   push that filled it does together with its memory write, so the write has always landed before the read
// reset clears ring pointers, enables and receiver ready, sets transmitter
//   ready and loads default base and vector; ring contents stay undefined
// when the receiver stalls, the output register holds its word and one more
//   word may enter the pipeline stage behind it; after that o_ready drops
module serial_console_terminal_regs_top
    import sctr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic                 i_byte_access,
    input  logic [WORD_W-1:0]    i_address,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic [WORD_W-1:0]    i_key_char,
    // output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_W-1:0]    o_read_data,
    output logic                 o_ok,
    output logic                 o_address_trap,
    output logic                 o_irq_valid,
    output logic [VEC_W-1:0]     o_irq_vector,
    output logic                 o_tx_valid,
    output logic [WORD_W-1:0]    o_tx_char
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // configuration registers
    logic [WORD_W-1:0]  r_base_addr;
    logic [VBASE_W-1:0] r_vector_base;

    // device state
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic             r_rx_enable, n_rx_enable;
    logic             r_rx_ready, n_rx_ready;
    logic             r_tx_enable, n_tx_enable;
    logic             r_tx_ready, n_tx_ready;

    // pipeline stage waiting on the ring read, and output register
    logic    r_p_valid;
    t_result r_p, n_p;
    logic    r_p_pop, n_p_pop;
    logic    r_p_byte;
    logic    r_o_valid;
    t_result r_o, n_o;

    logic              accept;
    logic              o_adv;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] pop_data;

    // address decode
    logic [WORD_W-1:0] offset;
    logic              hit;
    logic              odd;
    logic [1:0]        port;
    logic [PTR_W-1:0]  head_nx;
    logic [PTR_W-1:0]  tail_nx;
    logic              empty;
    logic              full;
    logic [WORD_W-1:0] wr_word;
    logic              wr_en_bit;
    logic [VEC_W-1:0]  rx_vec;
    logic [VEC_W-1:0]  tx_vec;

    assign offset  = i_address - r_base_addr;
    assign hit     = (offset[WORD_W-1:3] == '0);
    assign odd     = offset[0];
    assign port    = offset[2:1];
    assign head_nx = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
    assign tail_nx = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
    assign empty   = (r_head == r_tail);
    assign full    = (head_nx == r_tail);
    // byte writes use the zero-extended low byte
    assign wr_word   = i_byte_access ? {8'd0, i_write_data[7:0]} : i_write_data;
    assign wr_en_bit = wr_word[ENABLE_POS];
    assign rx_vec    = {1'b0, r_vector_base};
    assign tx_vec    = {1'b0, r_vector_base} + XMIT_VEC_OFS;

    // pipeline flow: output register frees up or drains, stage P follows
    assign o_adv   = !r_o_valid || i_ready;
    assign o_ready = !r_p_valid || o_adv;
    assign accept  = i_valid && o_ready;

    // per-word decode, state update and ring access
    always_comb begin
        logic [WORD_W-1:0] v;
        v           = '0;
        n_p         = '0;
        n_p_pop     = 1'b0;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rx_enable = r_rx_enable;
        n_rx_ready  = r_rx_ready;
        n_tx_enable = r_tx_enable;
        n_tx_ready  = r_tx_ready;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (i_cmd)
            CMD_PUSH: begin
                if (!full) begin
                    ram_we = accept;
                    n_head = head_nx;
                    n_p.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (hit) begin
                    if (odd) begin
                        n_p.ok   = i_byte_access;
                        n_p.trap = !i_byte_access;
                    end else begin
                        n_p.ok     = 1'b1;
                        n_rx_ready = !empty;
                        unique case (port)
                            PORT_RCSR: begin
                                v[READY_POS]  = !empty;
                                v[ENABLE_POS] = r_rx_enable;
                            end
                            PORT_RBUF: begin
                                n_rx_ready = 1'b0;
                                if (!empty) begin
                                    ram_re  = accept;
                                    n_p_pop = 1'b1;
                                    n_tail  = tail_nx;
                                end
                            end
                            PORT_XCSR: begin
                                v[READY_POS]  = r_tx_ready;
                                v[ENABLE_POS] = r_tx_enable;
                            end
                            PORT_XBUF: begin
                                v = '0;
                            end
                            default: begin
                                v = '0;
                            end
                        endcase
                        n_p.rdata = v;
                    end
                end
            end
            CMD_WRITE: begin
                if (hit) begin
                    if (odd) begin
                        n_p.ok   = !i_byte_access;
                        n_p.trap = !i_byte_access;
                    end else begin
                        n_p.ok = 1'b1;
                        unique case (port)
                            PORT_RCSR: begin
                                n_rx_enable = wr_en_bit;
                                if (wr_en_bit && r_rx_ready) begin
                                    n_p.irq = 1'b1;
                                    n_p.vec = rx_vec;
                                end
                            end
                            PORT_RBUF: begin
                                n_p.ok = 1'b1;
                            end
                            PORT_XCSR: begin
                                n_tx_enable = wr_en_bit;
                                if (wr_en_bit && r_tx_ready) begin
                                    n_p.irq = 1'b1;
                                    n_p.vec = tx_vec;
                                end
                            end
                            PORT_XBUF: begin
                                n_p.txv    = 1'b1;
                                n_p.txc    = wr_word;
                                n_tx_ready = 1'b1;
                                if (r_tx_enable) begin
                                    n_p.irq = 1'b1;
                                    n_p.vec = tx_vec;
                                end
                            end
                            default: begin
                                n_p.ok = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default: begin
                // unused command: all-zero result, no state change
                n_p = '0;
            end
        endcase
    end

    // keyboard ring: push writes at head, receiver data read pops at tail
    sctr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (i_key_char),
        .i_re    (ram_re),
        .i_raddr (r_tail),
        .o_rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr   <= BASE_ADDR_RST;
            r_vector_base <= VECTOR_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDR:   r_base_addr   <= i_cfg_wdata;
                CFG_VECTOR_BASE: r_vector_base <= i_cfg_wdata[VBASE_W-1:0];
                default: begin
                    r_base_addr <= r_base_addr;
                end
            endcase
        end
    end

    // device state, updated as each word is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_rx_enable <= 1'b0;
            r_rx_ready  <= 1'b0;
            r_tx_enable <= 1'b0;
            r_tx_ready  <= 1'b1;
        end else if (accept) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_rx_enable <= n_rx_enable;
            r_rx_ready  <= n_rx_ready;
            r_tx_enable <= n_tx_enable;
            r_tx_ready  <= n_tx_ready;
        end
    end

    // stage P: result waiting for the ring read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_ready) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p      <= n_p;
            r_p_pop  <= n_p_pop;
            r_p_byte <= i_byte_access;
        end
    end

    // popped character, byte reads keep the low byte only
    assign pop_data = r_p_byte ? {8'd0, ram_rdata[7:0]} : ram_rdata;

    // stage P word with the popped character merged in
    always_comb begin
        n_o = r_p;
        if (r_p_pop) begin
            n_o.rdata = pop_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_adv) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_p_valid) begin
            r_o <= n_o;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_read_data    = r_o.rdata;
    assign o_ok           = r_o.ok;
    assign o_address_trap = r_o.trap;
    assign o_irq_valid    = r_o.irq;
    assign o_irq_vector   = r_o.vec;
    assign o_tx_valid     = r_o.txv;
    assign o_tx_char      = r_o.txc;

endmodule

>>> rtl/sctr_checker.sv
`include "assert_macros.svh"

module sctr_checker
    import sctr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [WORD_W-1:0]    o_read_data,
    input logic                 o_ok,
    input logic                 o_address_trap,
    input logic                 o_irq_valid,
    input logic [VEC_W-1:0]     o_irq_vector,
    input logic                 o_tx_valid,
    input logic [WORD_W-1:0]    o_tx_char
);

    logic    out_stall;
    logic    side_fx;
    t_result out_bits;

    assign out_stall = o_valid && !i_ready;
    assign side_fx   = o_irq_valid || o_tx_valid;
    assign out_bits  = {o_read_data, o_ok, o_address_trap, o_irq_valid,
                        o_irq_vector, o_tx_valid, o_tx_char};

    // a trapped access has no side effects
    `SCTR_ASSERT_NOW(a_trap_quiet, o_valid && o_address_trap, !side_fx, "trap with side effect")

    // vector only shown with a request
    `SCTR_ASSERT_NOW(a_vec_zero, o_valid && !o_irq_valid, o_irq_vector == '0, "stray irq vector")

    // character only shown when transmitting
    `SCTR_ASSERT_NOW(a_txc_zero, o_valid && !o_tx_valid, o_tx_char == '0, "stray tx char")

    // stalled result word holds
    `SCTR_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable(out_bits), "stalled word changed")

    // no result right out of reset
    `SCTR_ASSERT_RST(a_rst_empty, $rose(i_rst_n), !o_valid, "result valid after reset")

endmodule

bind serial_console_terminal_regs_top sctr_checker u_sctr_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sctr_pkg::*;

    // cmd value the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // receiver hold-off used to back the block up
    localparam int RX_HOLD_CYCLES = 300;
    // cycles with no word moving on either channel before giving up
    localparam int WATCHDOG_LIMIT = 4000;

    // one input word, with an optional typed expectation
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              byte_acc;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
        logic [WORD_W-1:0] kchar;
        logic              has_exp;
        t_result           exp;
    } bus_word_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_wdata;
    logic                 i_valid;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_cmd;
    logic                 i_byte_access;
    logic [WORD_W-1:0]    i_address;
    logic [WORD_W-1:0]    i_write_data;
    logic [WORD_W-1:0]    i_key_char;
    logic                 o_valid;
    logic                 i_ready;
    logic [WORD_W-1:0]    o_read_data;
    logic                 o_ok;
    logic                 o_address_trap;
    logic                 o_irq_valid;
    logic [VEC_W-1:0]     o_irq_vector;
    logic                 o_tx_valid;
    logic [WORD_W-1:0]    o_tx_char;

    // typed expectation travels with the word, driven like the payload
    logic    drv_has_exp;
    t_result drv_exp;

    // predicted device state and configuration
    logic [WORD_W-1:0]  key_fifo [RING_DEPTH_DEF];
    logic [3:0]         key_wr_ptr;
    logic [3:0]         key_rd_ptr;
    logic               rx_ie;
    logic               rx_done;
    logic               tx_ie;
    logic               tx_done;
    logic [WORD_W-1:0]  dev_base;
    logic [VBASE_W-1:0] dev_vbase;

    // results still owed by the block, oldest first
    t_result pending_results [$];

    int      err_cnt = 0;
    int      res_cnt = 0;
    int      idle_cycles = 0;
    bit      tx_gap_free = 1'b0;
    bit      rx_stall_free = 1'b0;
    bit      rx_long_hold = 1'b0;
    t_result got_res;
    t_result want_res;
    t_result pred_res;

    serial_console_terminal_regs_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_byte_access  (i_byte_access),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_key_char     (i_key_char),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_data    (o_read_data),
        .o_ok           (o_ok),
        .o_address_trap (o_address_trap),
        .o_irq_valid    (o_irq_valid),
        .o_irq_vector   (o_irq_vector),
        .o_tx_valid     (o_tx_valid),
        .o_tx_char      (o_tx_char)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result word, all fields listed
    function automatic t_result res(input logic [WORD_W-1:0] rdata, input logic ok,
                                    input logic trap, input logic irq,
                                    input logic [VEC_W-1:0] vec, input logic txv,
                                    input logic [WORD_W-1:0] txc);
        t_result r;
        r.rdata = rdata;
        r.ok    = ok;
        r.trap  = trap;
        r.irq   = irq;
        r.vec   = vec;
        r.txv   = txv;
        r.txc   = txc;
        return r;
    endfunction

    function automatic bus_word_t row(input logic [CMD_W-1:0] cmd, input logic byte_acc,
                                      input logic [WORD_W-1:0] addr,
                                      input logic [WORD_W-1:0] wdata,
                                      input logic [WORD_W-1:0] kchar,
                                      input logic has_exp, input t_result exp);
        bus_word_t w;
        w.cmd      = cmd;
        w.byte_acc = byte_acc;
        w.addr     = addr;
        w.wdata    = wdata;
        w.kchar    = kchar;
        w.has_exp  = has_exp;
        w.exp      = exp;
        return w;
    endfunction

    // byte address of a register, optionally the odd byte of it
    function automatic logic [WORD_W-1:0] reg_addr(input logic [WORD_W-1:0] base,
                                                   input logic [1:0] port, input logic odd);
        return base + {13'd0, port, odd};
    endfunction

    function automatic logic [WORD_W-1:0] csr_word(input logic rdy, input logic ie);
        logic [WORD_W-1:0] v;
        v = '0;
        v[READY_POS]  = rdy;
        v[ENABLE_POS] = ie;
        return v;
    endfunction

    // console register behavior: one bus access or key push, one result
    function automatic t_result console_access(input logic [CMD_W-1:0] cmd,
                                               input logic byte_acc,
                                               input logic [WORD_W-1:0] addr,
                                               input logic [WORD_W-1:0] wdata,
                                               input logic [WORD_W-1:0] kchar);
        t_result           r;
        logic [WORD_W-1:0] ofs;
        logic [1:0]        port;
        logic              hit;
        logic              odd;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] d;
        logic              ie;
        logic [3:0]        nxt;
        logic [VEC_W-1:0]  xmit_vec;

        r        = '0;
        ofs      = addr - dev_base;
        port     = ofs[2:1];
        hit      = (ofs < 16'd8);
        odd      = ofs[0];
        nxt      = key_wr_ptr + 4'd1;
        xmit_vec = {1'b0, dev_vbase} + XMIT_VEC_OFS;

        case (cmd)
            CMD_PUSH: begin
                // full ring refuses the key
                if (nxt != key_rd_ptr) begin
                    key_fifo[key_wr_ptr] = kchar;
                    key_wr_ptr = nxt;
                    r.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (hit && odd) begin
                    if (byte_acc) r.ok = 1'b1;
                    else r.trap = 1'b1;
                end else if (hit) begin
                    v = '0;
                    rx_done = (key_wr_ptr != key_rd_ptr);
                    case (port)
                        PORT_RCSR: v = csr_word(rx_done, rx_ie);
                        PORT_RBUF: begin
                            if (key_wr_ptr != key_rd_ptr) begin
                                v = key_fifo[key_rd_ptr];
                                key_rd_ptr = key_rd_ptr + 4'd1;
                            end
                            rx_done = 1'b0;
                        end
                        PORT_XCSR: v = csr_word(tx_done, tx_ie);
                        default: v = '0;
                    endcase
                    r.rdata = byte_acc ? {8'h00, v[7:0]} : v;
                    r.ok = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (hit && odd) begin
                    if (!byte_acc) begin
                        r.trap = 1'b1;
                        r.ok = 1'b1;
                    end
                end else if (hit) begin
                    d = byte_acc ? {8'h00, wdata[7:0]} : wdata;
                    ie = d[ENABLE_POS];
                    r.ok = 1'b1;
                    case (port)
                        PORT_RCSR: begin
                            rx_ie = ie;
                            if (ie && rx_done) begin
                                r.irq = 1'b1;
                                r.vec = {1'b0, dev_vbase};
                            end
                        end
                        PORT_XCSR: begin
                            tx_ie = ie;
                            if (ie && tx_done) begin
                                r.irq = 1'b1;
                                r.vec = xmit_vec;
                            end
                        end
                        PORT_XBUF: begin
                            r.txv = 1'b1;
                            r.txc = d;
                            tx_done = 1'b1;
                            if (tx_ie) begin
                                r.irq = 1'b1;
                                r.vec = xmit_vec;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // wait per word, often none
    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 18)) : 0;
    endfunction

    // random word, mostly aimed at the device window
    function automatic bus_word_t random_word(input int push_pct);
        bus_word_t  w;
        int         sel;
        logic [1:0] port;

        w = '0;
        if ($urandom_range(0, 99) < push_pct) begin
            w.cmd = CMD_PUSH;
        end else begin
            sel = $urandom_range(0, 19);
            w.cmd = (sel < 10) ? CMD_READ : (sel < 19) ? CMD_WRITE : CMD_UNUSED;
        end
        w.byte_acc = ($urandom_range(0, 3) == 0);
        // lean on the receiver data register so the ring drains too
        port = ($urandom_range(0, 2) == 0) ? PORT_RBUF : 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel < 8)
            w.addr = reg_addr(dev_base, port, ($urandom_range(0, 5) == 0));
        else if (sel == 8)
            w.addr = ($urandom_range(0, 1) == 1) ? dev_base + 16'($urandom_range(8, 15))
                                                  : dev_base - 16'($urandom_range(1, 8));
        else
            w.addr = 16'($urandom);
        w.wdata = 16'($urandom);
        w.kchar = 16'($urandom);
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h", res_cnt, name, got, want));
    endtask

    // offer one word, after its drawn gap, and hold it until accepted
    task automatic send_word(input bus_word_t w);
        int gap;
        gap = tx_gap_free ? 0 : draw_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= w.cmd;
        i_byte_access <= w.byte_acc;
        i_address     <= w.addr;
        i_write_data  <= w.wdata;
        i_key_char    <= w.kchar;
        drv_has_exp   <= w.has_exp;
        drv_exp       <= w.exp;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering and let every owed result come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers, back to back, block idle
    task automatic load_config(input logic [WORD_W-1:0] base, input logic [VBASE_W-1:0] vb);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE_ADDR;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_VECTOR_BASE;
        i_cfg_wdata <= {7'd0, vb};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // scoreboard: check leaving words, predict accepted ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ADDR:   dev_base = i_cfg_wdata;
                    CFG_VECTOR_BASE: dev_vbase = i_cfg_wdata[VBASE_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                got_res = res(o_read_data, o_ok, o_address_trap, o_irq_valid,
                              o_irq_vector, o_tx_valid, o_tx_char);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d came with nothing owed", res_cnt));
                end else begin
                    want_res = pending_results.pop_front();
                    cmp_field("read_data", got_res.rdata, want_res.rdata);
                    cmp_field("ok", {15'd0, got_res.ok}, {15'd0, want_res.ok});
                    cmp_field("address_trap", {15'd0, got_res.trap}, {15'd0, want_res.trap});
                    cmp_field("irq_valid", {15'd0, got_res.irq}, {15'd0, want_res.irq});
                    cmp_field("irq_vector", {6'd0, got_res.vec}, {6'd0, want_res.vec});
                    cmp_field("tx_valid", {15'd0, got_res.txv}, {15'd0, want_res.txv});
                    cmp_field("tx_char", got_res.txc, want_res.txc);
                end
                res_cnt++;
            end
            if (i_valid && o_ready) begin
                // predictor always runs so its state follows the block
                pred_res = console_access(i_cmd, i_byte_access, i_address,
                                          i_write_data, i_key_char);
                pending_results.push_back(drv_has_exp ? drv_exp : pred_res);
            end
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            if (rx_long_hold) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end else begin
                stall = rx_stall_free ? 0 : draw_gap();
                if (stall != 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        bus_word_t          dir_tab [$];
        bus_word_t          w;
        logic [WORD_W-1:0]  ph_base [5];
        logic [VBASE_W-1:0] ph_vb [5];
        int                 ph_items [5];
        int                 ph_push [5];
        bit                 ph_idle [5];
        logic [WORD_W-1:0]  b;

        // every input known from time zero
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BASE_ADDR;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_cmd         = CMD_READ;
        i_byte_access = 1'b0;
        i_address     = '0;
        i_write_data  = '0;
        i_key_char    = '0;
        drv_has_exp   = 1'b0;
        drv_exp       = '0;

        // predictor comes up like the block after reset
        foreach (key_fifo[k]) key_fifo[k] = '0;
        key_wr_ptr = '0;
        key_rd_ptr = '0;
        rx_ie      = 1'b0;
        rx_done    = 1'b0;
        tx_ie      = 1'b0;
        tx_done    = 1'b1;
        dev_base   = BASE_ADDR_RST;
        dev_vbase  = VECTOR_BASE_RST;

        b = BASE_ADDR_RST;
        // registers straight out of reset
        dir_tab.push_back(row(CMD_READ, 1'b0, reg_addr(b, PORT_RCSR, 1'b0), 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_READ, 1'b0, reg_addr(b, PORT_XCSR, 1'b0), 16'h0000, 16'h0000,
                              1'b1, res(16'h0080, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // transmitter data is write-only
        dir_tab.push_back(row(CMD_READ, 1'b0, reg_addr(b, PORT_XBUF, 1'b0), 16'hFFFF, 16'hFFFF,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // pop of an empty ring
        dir_tab.push_back(row(CMD_READ, 1'b0, reg_addr(b, PORT_RBUF, 1'b0), 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // odd word read and odd word write trap
        dir_tab.push_back(row(CMD_READ, 1'b0, reg_addr(b, PORT_RCSR, 1'b1), 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_RBUF, 1'b1), 16'hFFFF, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b1, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // odd byte read answers 0, odd byte write ignored
        dir_tab.push_back(row(CMD_READ, 1'b1, reg_addr(b, PORT_XCSR, 1'b1), 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_WRITE, 1'b1, reg_addr(b, PORT_XBUF, 1'b1), 16'hFFFF, 16'h0000,
                              1'b1, res(16'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // just past, just below and far from the window
        dir_tab.push_back(row(CMD_READ, 1'b0, b + 16'd8, 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_READ, 1'b0, b - 16'd1, 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_WRITE, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF,
                              1'b1, res(16'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // unused command does nothing
        dir_tab.push_back(row(CMD_UNUSED, 1'b1, reg_addr(b, PORT_XBUF, 1'b0), 16'hFFFF,
                              16'hFFFF, 1'b1,
                              res(16'h0000, 1'b0, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // transmitter enable while ready interrupts at base plus four
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_XCSR, 1'b0), 16'hFFFF, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b1, 10'd52, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_XBUF, 1'b0), 16'hFFFF, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b1, 10'd52, 1'b1, 16'hFFFF)));
        dir_tab.push_back(row(CMD_WRITE, 1'b1, reg_addr(b, PORT_XBUF, 1'b0), 16'hABCD, 16'h0000,
                              1'b0, '0));
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_XCSR, 1'b0), 16'h0000, 16'h0000,
                              1'b0, '0));
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_XBUF, 1'b0), 16'h1234, 16'h0000,
                              1'b0, '0));
        // key pushes at the extremes, address does not matter
        dir_tab.push_back(row(CMD_PUSH, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        dir_tab.push_back(row(CMD_PUSH, 1'b1, 16'h0000, 16'h0000, 16'h0000,
                              1'b1, res(16'h0000, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 16'h0000)));
        // receiver enable before a status read has set ready
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_RCSR, 1'b0), 16'h0040, 16'h0000,
                              1'b0, '0));
        dir_tab.push_back(row(CMD_READ, 1'b1, reg_addr(b, PORT_RCSR, 1'b0), 16'h0000, 16'h0000,
                              1'b0, '0));
        // byte write of the enable now interrupts
        dir_tab.push_back(row(CMD_WRITE, 1'b1, reg_addr(b, PORT_RCSR, 1'b0), 16'hFF40, 16'h0000,
                              1'b0, '0));
        dir_tab.push_back(row(CMD_READ, 1'b1, reg_addr(b, PORT_RBUF, 1'b0), 16'h0000, 16'h0000,
                              1'b0, '0));
        dir_tab.push_back(row(CMD_READ, 1'b0, reg_addr(b, PORT_RBUF, 1'b0), 16'h0000, 16'h0000,
                              1'b0, '0));
        // receiver data write ignored
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_RBUF, 1'b0), 16'hFFFF, 16'h0000,
                              1'b0, '0));
        dir_tab.push_back(row(CMD_WRITE, 1'b0, reg_addr(b, PORT_RCSR, 1'b0), 16'h0000, 16'h0000,
                              1'b0, '0));

        // phase settings: extremes, window wrapping past 0xffff, then random
        ph_base  = '{16'hFF70, 16'h0000, 16'hFFFF, 16'h1234, 16'($urandom)};
        ph_vb    = '{9'd48, 9'd0, 9'd511, 9'd255, 9'($urandom)};
        ph_items = '{180, 150, 180, 160, 180};
        ph_push  = '{30, 20, 45, 30, 25};
        ph_idle  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

        // synchronous reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_word(dir_tab[i]);

        for (int ph = 0; ph < 5; ph++) begin
            drain_results();
            load_config(ph_base[ph], ph_vb[ph]);
            tx_gap_free   = !ph_idle[ph];
            rx_stall_free = !ph_idle[ph];

            if (ph == 3) begin
                // receiver holds off while keys pour in back to back:
                // the pipeline fills, o_ready drops, the ring ends up full
                rx_long_hold = 1'b1;
                tx_gap_free  = 1'b1;
                repeat (20) begin
                    w = row(CMD_PUSH, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                            1'b0, '0);
                    send_word(w);
                end
                // then pop past empty
                repeat (20) begin
                    w = row(CMD_READ, 1'($urandom_range(0, 1)),
                            reg_addr(dev_base, PORT_RBUF, 1'b0), 16'($urandom),
                            16'($urandom), 1'b0, '0);
                    send_word(w);
                end
                tx_gap_free = !ph_idle[ph];
            end

            for (int n = 0; n < ph_items[ph]; n++) begin
                // sender pauses mid-phase until the block has emptied
                if (ph == 2 && n == ph_items[ph] / 2) drain_results();
                send_word(random_word(ph_push[ph]));
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
